// ===== design/rse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// shared types and constants of the rpn stack evaluator
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int DefStackDepth = 128;
  localparam int DataW = 64;

  typedef enum logic [3:0] {
    OP_PUSH     = 4'd0,
    OP_ADD      = 4'd1,
    OP_SUB      = 4'd2,
    OP_MUL      = 4'd3,
    OP_DIV      = 4'd4,
    OP_MOD      = 4'd5,
    OP_DUP      = 4'd6,
    OP_SWAP     = 4'd7,
    OP_PEEK     = 4'd8,
    OP_POP_SHOW = 4'd9,
    OP_CLEAR    = 4'd10
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_B,
    ST_WT_B,
    ST_RD_A,
    ST_WT_A,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_FIN,
    ST_WR1,
    ST_WR2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    WSEL_OPND,
    WSEL_A,
    WSEL_B,
    WSEL_RES,
    WSEL_ZERO
  } wsel_t;

  // controller to datapath
  typedef struct packed {
    logic    start_cmd;
    logic    rd_b;
    logic    rd_a;
    logic    lat_b;
    logic    lat_a;
    logic    mul_step;
    logic    div_step;
    logic    fin;
    logic    wr;
    wsel_t   wsel;
    logic    clr;
    logic    peek;
    logic    lat_show;
    logic    set_dz;
    logic    done;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic b_zero;
    logic div_last;
    op_t  op;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/rse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ctrl
// command sequencer: operand reads, arithmetic steps and stack writes
// ----------------------------------------------------------------------------
module rse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  rse_pkg::sts_t      sts,
  output rse_pkg::ctl_t      ctl
);

  rse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rse_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl = '0;
    ctl.wsel = rse_pkg::WSEL_OPND;
    state_nxt = state_r;
    busy = (state_r != rse_pkg::ST_IDLE);
    unique case (state_r)
      rse_pkg::ST_IDLE: begin
        if (start) begin
          ctl.start_cmd = 1'b1;
          state_nxt = rse_pkg::ST_RD_B;
        end
      end
      rse_pkg::ST_RD_B: begin
        case (sts.op)
          rse_pkg::OP_PUSH: begin
            ctl.wr = 1'b1;
            ctl.wsel = rse_pkg::WSEL_OPND;
            state_nxt = rse_pkg::ST_DONE;
          end
          rse_pkg::OP_CLEAR: begin
            ctl.clr = 1'b1;
            state_nxt = rse_pkg::ST_DONE;
          end
          rse_pkg::OP_PEEK: begin
            ctl.peek = 1'b1;
            ctl.rd_b = 1'b1;
            state_nxt = rse_pkg::ST_WT_B;
          end
          rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL, rse_pkg::OP_DIV,
          rse_pkg::OP_MOD, rse_pkg::OP_DUP, rse_pkg::OP_SWAP,
          rse_pkg::OP_POP_SHOW: begin
            ctl.rd_b = 1'b1;
            state_nxt = rse_pkg::ST_WT_B;
          end
          default: state_nxt = rse_pkg::ST_DONE;
        endcase
      end
      rse_pkg::ST_WT_B: begin
        ctl.lat_b = 1'b1;
        case (sts.op)
          rse_pkg::OP_PEEK, rse_pkg::OP_POP_SHOW: begin
            ctl.lat_show = 1'b1;
            state_nxt = rse_pkg::ST_DONE;
          end
          rse_pkg::OP_DUP: state_nxt = rse_pkg::ST_WR1;
          default: state_nxt = rse_pkg::ST_RD_A;
        endcase
      end
      rse_pkg::ST_RD_A: begin
        if (sts.op == rse_pkg::OP_DIV && sts.b_zero) begin
          ctl.set_dz = 1'b1;
          state_nxt = rse_pkg::ST_DONE;
        end else begin
          ctl.rd_a = 1'b1;
          state_nxt = rse_pkg::ST_WT_A;
        end
      end
      rse_pkg::ST_WT_A: begin
        ctl.lat_a = 1'b1;
        case (sts.op)
          rse_pkg::OP_MUL: state_nxt = rse_pkg::ST_MUL0;
          rse_pkg::OP_DIV, rse_pkg::OP_MOD: begin
            if (sts.b_zero) begin
              ctl.set_dz = 1'b1;
              state_nxt = rse_pkg::ST_WR1;
            end else begin
              state_nxt = rse_pkg::ST_DIV;
            end
          end
          rse_pkg::OP_SWAP: state_nxt = rse_pkg::ST_WR1;
          default: state_nxt = rse_pkg::ST_FIN;
        endcase
      end
      rse_pkg::ST_MUL0, rse_pkg::ST_MUL1, rse_pkg::ST_MUL2: begin
        ctl.mul_step = 1'b1;
        state_nxt = rse_pkg::state_t'(state_r + 5'd1);
      end
      rse_pkg::ST_MUL3: begin
        ctl.mul_step = 1'b1;
        state_nxt = rse_pkg::ST_FIN;
      end
      rse_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) state_nxt = rse_pkg::ST_FIN;
      end
      rse_pkg::ST_FIN: begin
        ctl.fin = 1'b1;
        state_nxt = rse_pkg::ST_WR1;
      end
      rse_pkg::ST_WR1: begin
        ctl.wr = 1'b1;
        case (sts.op)
          rse_pkg::OP_DUP: begin
            ctl.wsel = rse_pkg::WSEL_B;
            state_nxt = rse_pkg::ST_WR2;
          end
          rse_pkg::OP_SWAP: begin
            ctl.wsel = rse_pkg::WSEL_B;
            state_nxt = rse_pkg::ST_WR2;
          end
          rse_pkg::OP_MOD: begin
            ctl.wsel = sts.b_zero ? rse_pkg::WSEL_ZERO : rse_pkg::WSEL_RES;
            state_nxt = rse_pkg::ST_DONE;
          end
          default: begin
            ctl.wsel = rse_pkg::WSEL_RES;
            state_nxt = rse_pkg::ST_DONE;
          end
        endcase
      end
      rse_pkg::ST_WR2: begin
        ctl.wr = 1'b1;
        ctl.wsel = (sts.op == rse_pkg::OP_DUP) ? rse_pkg::WSEL_B : rse_pkg::WSEL_A;
        state_nxt = rse_pkg::ST_DONE;
      end
      rse_pkg::ST_DONE: begin
        ctl.done = 1'b1;
        state_nxt = rse_pkg::ST_IDLE;
      end
      default: state_nxt = rse_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/rse_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_dp
// stack memory, pointer, multiplier, radix-2 divider and flags
// ----------------------------------------------------------------------------
module rse_dp #(
  parameter int STACK_DEPTH = rse_pkg::DefStackDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [3:0]    in_op,
  input  wire logic [63:0]   in_operand,
  input  rse_pkg::ctl_t      ctl,
  output rse_pkg::sts_t      sts,
  output logic               out_valid,
  output logic [63:0]        out_shown_value,
  output logic               out_shown,
  output logic               out_underflow,
  output logic               out_overflow,
  output logic               out_div_zero,
  output logic               out_saturated,
  output logic [7:0]         out_stack_depth
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);
  localparam logic [63:0] QMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QMIN = 64'h8000_0000_0000_0000;

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] rdata_r;
  logic [PW-1:0] sp_r;
  rse_pkg::op_t op_r;
  logic [63:0] opnd_r, a_r, b_r, res_r, show_r;
  logic under_r, over_r, dz_r, sat_r, shown_r, rd_empty_r;
  logic [127:0] prod_r;
  logic [1:0] mcnt_r;
  logic [6:0] dcnt_r;
  logic [95:0] num_r;
  logic [64:0] rem_r;
  logic [63:0] quo_r;
  logic big_r;
  logic [63:0] wdata;
  logic empty;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  assign empty = (sp_r == '0);
  assign sts.b_zero = (b_r == 64'd0);
  assign sts.div_last = (dcnt_r == 7'd95);
  assign sts.op = op_r;

  always_comb begin
    case (ctl.wsel)
      rse_pkg::WSEL_A:   wdata = a_r;
      rse_pkg::WSEL_B:   wdata = b_r;
      rse_pkg::WSEL_RES: wdata = res_r;
      rse_pkg::WSEL_ZERO: wdata = 64'd0;
      default:           wdata = opnd_r;
    endcase
  end

  // memory and stack pointer
  always_ff @(posedge clk) begin
    if (ctl.wr && sp_r < FULL) mem[sp_r[AW-1:0]] <= wdata;
    if ((ctl.rd_b || ctl.rd_a) && !empty) rdata_r <= mem[AW'(sp_r - PW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (ctl.clr) begin
      sp_r <= '0;
    end else if (ctl.wr) begin
      if (sp_r < FULL) sp_r <= sp_r + PW'(1);
    end else if ((ctl.rd_b && !ctl.peek) || ctl.rd_a) begin
      if (!empty) sp_r <= sp_r - PW'(1);
    end
  end

  // arithmetic working registers
  logic [63:0] xa, xb;
  logic [31:0] mx, my;
  logic [63:0] pp;
  logic [64:0] rtrial;
  logic [63:0] opv;
  assign xa = mag(a_r);
  assign xb = mag(b_r);
  assign mx = mcnt_r[1] ? xa[63:32] : xa[31:0];
  assign my = mcnt_r[0] ? xb[63:32] : xb[31:0];
  assign pp = mx * my;
  assign rtrial = {rem_r[63:0], num_r[95]};
  assign opv = rd_empty_r ? 64'd0 : rdata_r;

  logic [64:0] addr, subr;
  logic negr, bigr;
  logic [63:0] magr;
  assign addr = {a_r[63], a_r} + {b_r[63], b_r};
  assign subr = {a_r[63], a_r} - {b_r[63], b_r};

  always_comb begin
    negr = a_r[63] ^ b_r[63];
    magr = quo_r;
    bigr = big_r;
    if (op_r == rse_pkg::OP_MUL) begin
      magr = prod_r[95:32];
      bigr = (prod_r[127:96] != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.done;
    end
    if (ctl.start_cmd) begin
      op_r <= rse_pkg::op_t'(in_op);
      opnd_r <= in_operand;
      under_r <= 1'b0;
      over_r <= 1'b0;
      dz_r <= 1'b0;
      sat_r <= 1'b0;
      shown_r <= (in_op == rse_pkg::OP_PEEK) || (in_op == rse_pkg::OP_POP_SHOW);
      show_r <= 64'd0;
    end
    if (ctl.rd_b || ctl.rd_a) begin
      rd_empty_r <= empty;
      if (empty) under_r <= 1'b1;
    end
    if (ctl.wr && sp_r >= FULL) over_r <= 1'b1;
    if (ctl.set_dz) dz_r <= 1'b1;
    if (ctl.lat_b) b_r <= opv;
    if (ctl.lat_show) show_r <= opv;
    if (ctl.lat_a) begin
      a_r <= opv;
      prod_r <= '0;
      mcnt_r <= '0;
      dcnt_r <= '0;
      // mod divides the plain magnitude, div the magnitude scaled by 2^32
      num_r <= (op_r == rse_pkg::OP_MOD) ? {32'd0, mag(opv)} : {mag(opv), 32'd0};
      rem_r <= '0;
      quo_r <= '0;
      big_r <= 1'b0;
    end
    if (ctl.mul_step) begin
      prod_r <= prod_r + ({64'd0, pp} << (7'(mcnt_r[1]) * 7'd32 + 7'(mcnt_r[0]) * 7'd32));
      mcnt_r <= mcnt_r + 2'd1;
    end
    if (ctl.div_step) begin
      num_r <= {num_r[94:0], 1'b0};
      dcnt_r <= dcnt_r + 7'd1;
      if (rtrial >= {1'b0, xb}) begin
        rem_r <= rtrial - {1'b0, xb};
        if (dcnt_r < 7'd32) big_r <= 1'b1;
        else quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rtrial;
        if (dcnt_r >= 7'd32) quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (ctl.fin) begin
      case (op_r)
        rse_pkg::OP_ADD: begin
          if (addr[64] != addr[63]) begin
            sat_r <= 1'b1;
            res_r <= a_r[63] ? QMIN : QMAX;
          end else begin
            res_r <= addr[63:0];
          end
        end
        rse_pkg::OP_SUB: begin
          if (subr[64] != subr[63]) begin
            sat_r <= 1'b1;
            res_r <= a_r[63] ? QMIN : QMAX;
          end else begin
            res_r <= subr[63:0];
          end
        end
        rse_pkg::OP_MOD: res_r <= a_r[63] ? (64'd0 - rem_r[63:0]) : rem_r[63:0];
        default: begin
          if (negr) begin
            if (bigr || magr > QMIN) begin
              sat_r <= 1'b1;
              res_r <= QMIN;
            end else begin
              res_r <= 64'd0 - magr;
            end
          end else if (bigr || magr > QMAX) begin
            sat_r <= 1'b1;
            res_r <= QMAX;
          end else begin
            res_r <= magr;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_shown_value = show_r;
    out_shown = shown_r;
    out_underflow = under_r;
    out_overflow = over_r;
    out_div_zero = dz_r;
    out_saturated = sat_r;
    out_stack_depth = 8'(sp_r);
  end

endmodule
`default_nettype wire

// ===== design/rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// reverse-polish Q32.32 value stack with saturating arithmetic
// ----------------------------------------------------------------------------
// channel   ports                                  handshake
// input     in_op, in_operand                      start & !busy
// result    out_shown_value .. out_stack_depth     out_valid, one cycle
//
// div and mod run the radix-2 divider at one bit per cycle over 96 steps;
// a zero divisor skips the divider and sets out_div_zero, and mod then
// pushes zero in place of the result
// synchronous reset empties the stack; memory contents are left as they are
// busy holds off new commands until the result strobe
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::DefStackDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [3:0]    in_op,
  input  wire logic signed [63:0] in_operand,
  output logic               out_valid,
  output logic signed [63:0] out_shown_value,
  output logic               out_shown,
  output logic               out_underflow,
  output logic               out_overflow,
  output logic               out_div_zero,
  output logic               out_saturated,
  output logic [7:0]         out_stack_depth
);

  rse_pkg::ctl_t ctl;
  rse_pkg::sts_t sts;

  rse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  rse_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_operand      (in_operand),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_shown_value (out_shown_value),
    .out_shown       (out_shown),
    .out_underflow   (out_underflow),
    .out_overflow    (out_overflow),
    .out_div_zero    (out_div_zero),
    .out_saturated   (out_saturated),
    .out_stack_depth (out_stack_depth)
  );

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(start && !busy))
    else $error("result strobe right after accept");

  a_no_shown_without_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_shown) |-> (out_shown_value == 64'sd0))
    else $error("shown value nonzero on non-show command");

  a_idle_after_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy during result strobe");

endmodule
`default_nettype wire
